>>> hw/rtl/gcra_pkg.sv
// ----------------------------------------------------------------------------
// Gimbal / chassis rate allocator package
// Shared types, fixed-point constants, register codes and clamp helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gcra_pkg;

  // Q6.12 / Q0.12 constants.
  localparam logic [13:0]        ONE_Q12    = 14'd4096;
  localparam logic [13:0]        MARGIN_Q12 = 14'd614;
  localparam logic signed [33:0] ROUND_BIAS = 34'sd2048;
  localparam logic signed [17:0] HOLD_LSB   = 18'sd4;

  // Number of quotient bits produced by the divider.
  localparam int unsigned DIV_STEPS = 13;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_YAW_LIMIT   = 3'd0;
  localparam logic [2:0] REG_PITCH_LIMIT = 3'd1;
  localparam logic [2:0] REG_LIN_LIMIT   = 3'd2;
  localparam logic [2:0] REG_ANG_LIMIT   = 3'd3;
  localparam logic [2:0] REG_RATIO       = 3'd4;
  localparam logic [2:0] REG_ALPHA       = 3'd5;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [16:0] yaw_limit;
    logic [16:0] pitch_limit;
    logic [16:0] lin_limit;
    logic [16:0] ang_limit;
    logic [12:0] ratio;
    logic [12:0] alpha;
  } cfg_t;

  // Request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic               en;
    logic               clr;
    logic signed [18:0] a;
    logic signed [13:0] b;
  } mac_req_t;

  // Request to the divider: remainder seed, low numerator bits, divisor.
  typedef struct packed {
    logic        start;
    logic [16:0] rem_init;
    logic [12:0] num_lo;
    logic [16:0] divisor;
  } div_req_t;

  // Divider status.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [12:0] quot;
  } div_rsp_t;

  // Symmetric clamp of a wide signed value to +-lim.
  function automatic logic signed [17:0] clamp_sym(input logic signed [21:0] v,
                                                   input logic [16:0] lim);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    logic signed [21:0] res;
    hi = $signed({5'b0, lim});
    lo = -hi;
    if (v > hi) begin
      res = hi;
    end else if (v < lo) begin
      res = lo;
    end else begin
      res = v;
    end
    return res[17:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gcra_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed 19x14 multiply per cycle into a registered accumulator that can
// be seeded with the rounding bias.
// ----------------------------------------------------------------------------
`default_nettype none

module gcra_mac (
  input  wire logic                clk,
  input  wire gcra_pkg::mac_req_t  req,
  output logic signed [33:0]       acc
);

  logic signed [32:0] prod;
  logic signed [33:0] acc_r;
  logic signed [33:0] acc_nxt;

  // Product plus either the running sum or the round-to-nearest bias.
  always_comb begin
    prod    = req.a * req.b;
    acc_nxt = (req.clr ? gcra_pkg::ROUND_BIAS : acc_r) + {prod[32], prod};
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/gcra_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces a 13-bit quotient, one bit per cycle, for a numerator whose upper
// part is already below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module gcra_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gcra_pkg::div_req_t req,
  output gcra_pkg::div_rsp_t      rsp
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [16:0] rem_r;
  logic [12:0] num_r;
  logic [12:0] quot_r;
  logic [16:0] divisor_r;

  logic [17:0] trial;
  logic        fits;
  logic [17:0] diff;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, num_r[12]};
    fits  = trial >= {1'b0, divisor_r};
    diff  = trial - {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r    <= 1'b1;
        cnt_r     <= 4'(gcra_pkg::DIV_STEPS - 1);
        rem_r     <= req.rem_init;
        num_r     <= req.num_lo;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[16:0] : trial[16:0];
        num_r  <= {num_r[11:0], 1'b0};
        quot_r <= {quot_r[11:0], fits};
        cnt_r  <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

>>> hw/rtl/gcra_regs.sv
// ----------------------------------------------------------------------------
// Configuration register bank
// APB-style write and read of the six limit, ratio and filter registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gcra_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output gcra_pkg::cfg_t   cfg
);

  gcra_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;
  logic [12:0]    v13;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // Fractions above one saturate to one when written.
  always_comb begin
    v13 = cfg_pwdata[12:0];
    if (v13 > gcra_pkg::ONE_Q12[12:0]) begin
      v13 = gcra_pkg::ONE_Q12[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yaw_limit   <= 17'd12868;
      cfg_r.pitch_limit <= 17'd6434;
      cfg_r.lin_limit   <= 17'd4096;
      cfg_r.ang_limit   <= 17'd8192;
      cfg_r.ratio       <= 13'd2048;
      cfg_r.alpha       <= 13'd1229;
    end else if (wr_en) begin
      unique case (idx)
        gcra_pkg::REG_YAW_LIMIT:   cfg_r.yaw_limit   <= cfg_pwdata[16:0];
        gcra_pkg::REG_PITCH_LIMIT: cfg_r.pitch_limit <= cfg_pwdata[16:0];
        gcra_pkg::REG_LIN_LIMIT:   cfg_r.lin_limit   <= cfg_pwdata[16:0];
        gcra_pkg::REG_ANG_LIMIT:   cfg_r.ang_limit   <= cfg_pwdata[16:0];
        gcra_pkg::REG_RATIO:       cfg_r.ratio       <= v13;
        gcra_pkg::REG_ALPHA:       cfg_r.alpha       <= v13;
        default: begin
        end
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      gcra_pkg::REG_YAW_LIMIT:   cfg_prdata = {15'b0, cfg_r.yaw_limit};
      gcra_pkg::REG_PITCH_LIMIT: cfg_prdata = {15'b0, cfg_r.pitch_limit};
      gcra_pkg::REG_LIN_LIMIT:   cfg_prdata = {15'b0, cfg_r.lin_limit};
      gcra_pkg::REG_ANG_LIMIT:   cfg_prdata = {15'b0, cfg_r.ang_limit};
      gcra_pkg::REG_RATIO:       cfg_prdata = {19'b0, cfg_r.ratio};
      gcra_pkg::REG_ALPHA:       cfg_prdata = {19'b0, cfg_r.alpha};
      default:                   cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/gimbal_chassis_rate_allocator_core.sv
// ----------------------------------------------------------------------------
// Gimbal / chassis rate allocator core
// Splits camera rotation between gimbal and chassis, clamps chassis speeds
// and low-pass filters the gimbal rate commands.
// ----------------------------------------------------------------------------
// Sequence: per axis (yaw, then pitch) margin, saturation check with a divide
// only when the angle is inside its margin, factor, gimbal rate and filter;
// then chassis share and chassis yaw. A new request is taken only in idle, once
// the result is published; the sequencer issues one multiply per step on the shared MAC.
// Reset (synchronous, active low) clears the sequencer, the output valid flag
// and the filter history, and loads the register defaults.
`default_nettype none

module gimbal_chassis_rate_allocator_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, low bit up: cam_vx, cam_vz, cam_wx, cam_wy, gimbal_yaw_angle,
  // gimbal_pitch_angle (18 bits each), 4 bits zero fill
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,
  // out_tdata, low bit up: gimbal_yaw_cmd, gimbal_pitch_cmd, chassis_forward,
  // chassis_lateral, chassis_yaw_cmd (18 bits each), 6 bits zero fill
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,
  // out_tuser, low bit up: hold_yaw, hold_pitch
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MARGIN_ISS, ST_MARGIN_WB, ST_SAT_CHK, ST_DIV_RUN,
    ST_FACT_ISS, ST_FACT_WB, ST_GIMB_ISS, ST_GIMB_WB, ST_SM1_ISS,
    ST_SM2_ISS, ST_SM_WB, ST_SHARE_ISS, ST_SHARE_WB, ST_CY_ISS, ST_DONE
  } state_t;

  gcra_pkg::cfg_t     cfg;
  gcra_pkg::mac_req_t mac_req;
  gcra_pkg::div_req_t div_req;
  gcra_pkg::div_rsp_t div_rsp;
  logic signed [33:0] mac_acc;

  state_t             state_r;
  logic               ax_r;
  logic signed [17:0] vx_r, vz_r;
  logic signed [18:0] yaw_rate_r, pitch_rate_r;
  logic signed [17:0] yaw_ang_r, pitch_ang_r;
  logic [16:0]        eff_r;
  logic [12:0]        sat_r;
  logic [12:0]        ysat_r;
  logic [12:0]        factor_r;
  logic signed [17:0] gim_r;
  logic [12:0]        share_r;
  logic signed [17:0] prev_yaw_r, prev_pitch_r;
  logic signed [17:0] cy_r;
  logic               out_valid_r;
  logic [95:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;

  logic               in_acc;
  logic [16:0]        ax_lim;
  logic signed [17:0] ax_ang;
  logic signed [18:0] ax_rate;
  logic signed [17:0] ax_prev;
  logic [17:0]        ang_abs;
  logic signed [21:0] acc_rnd;
  logic [16:0]        eff_calc;
  logic               sat_full;
  logic [29:0]        num_full;
  logic signed [18:0] ang_ext;
  logic signed [18:0] eff_pos;
  logic               push_out;
  logic [13:0]        one_m_ratio;
  logic [13:0]        one_m_alpha;
  logic signed [17:0] gim_clamp;
  logic signed [17:0] cy_clamp;
  logic signed [17:0] cmd_now;
  logic signed [17:0] fwd, lat;
  logic               out_free;

  gcra_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gcra_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (mac_acc)
  );

  gcra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Per-axis operand selection.
  always_comb begin
    ax_lim  = ax_r ? cfg.pitch_limit : cfg.yaw_limit;
    ax_ang  = ax_r ? pitch_ang_r : yaw_ang_r;
    ax_rate = ax_r ? pitch_rate_r : yaw_rate_r;
    ax_prev = ax_r ? prev_pitch_r : prev_yaw_r;
    ang_abs = ax_ang[17] ? 18'(-ax_ang) : 18'(ax_ang);
  end

  // Rounded MAC result and the per-axis decisions built on it.
  always_comb begin
    acc_rnd     = mac_acc[33:12];
    eff_calc    = ax_lim - acc_rnd[16:0];
    sat_full    = (eff_r == 17'd0) || (ang_abs >= {1'b0, eff_r});
    num_full    = {ang_abs[16:0], 12'b0} + {14'b0, eff_r[16:1]};
    ang_ext     = {ax_ang[17], ax_ang};
    eff_pos     = $signed({2'b0, eff_r});
    push_out    = ((ang_ext >= eff_pos) && (ax_rate > 19'sd0)) ||
                  ((ang_ext <= -eff_pos) && (ax_rate < 19'sd0));
    one_m_ratio = gcra_pkg::ONE_Q12 - {1'b0, cfg.ratio};
    one_m_alpha = gcra_pkg::ONE_Q12 - {1'b0, cfg.alpha};
    gim_clamp   = gcra_pkg::clamp_sym(acc_rnd, ax_lim);
    cy_clamp    = gcra_pkg::clamp_sym(acc_rnd, cfg.ang_limit);
    cmd_now     = acc_rnd[17:0];
    fwd         = gcra_pkg::clamp_sym({{4{vz_r[17]}}, vz_r}, cfg.lin_limit);
    lat         = gcra_pkg::clamp_sym(-{{4{vx_r[17]}}, vx_r}, cfg.lin_limit);
  end

  // Operand steering for the shared MAC.
  always_comb begin
    mac_req = '0;
    unique case (state_r)
      ST_MARGIN_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b1, a: $signed({2'b0, ax_lim}),
                    b: $signed(gcra_pkg::MARGIN_Q12)};
      end
      ST_FACT_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b1, a: $signed({5'b0, one_m_ratio}),
                    b: $signed(gcra_pkg::ONE_Q12 - {1'b0, sat_r})};
      end
      ST_GIMB_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b1, a: ax_rate, b: $signed({1'b0, factor_r})};
      end
      ST_SM1_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b1, a: {gim_r[17], gim_r},
                    b: $signed({1'b0, cfg.alpha})};
      end
      ST_SM2_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b0, a: {ax_prev[17], ax_prev},
                    b: $signed(one_m_alpha)};
      end
      ST_SHARE_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b1, a: $signed({6'b0, ysat_r}),
                    b: $signed(one_m_ratio)};
      end
      ST_CY_ISS: begin
        mac_req = '{en: 1'b1, clr: 1'b1, a: yaw_rate_r, b: $signed({1'b0, share_r})};
      end
      default: begin
      end
    endcase
  end

  // Divider launch when the angle is inside the margin.
  always_comb begin
    div_req.start    = (state_r == ST_SAT_CHK) && !sat_full;
    div_req.rem_init = num_full[29:13];
    div_req.num_lo   = num_full[12:0];
    div_req.divisor  = eff_r;
  end

  // Sequencer with its datapath and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ax_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_yaw_r   <= '0;
      prev_pitch_r <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            vx_r         <= in_tdata[17:0];
            vz_r         <= in_tdata[35:18];
            pitch_rate_r <= -{in_tdata[53], in_tdata[53:36]};
            yaw_rate_r   <= -{in_tdata[71], in_tdata[71:54]};
            yaw_ang_r    <= in_tdata[89:72];
            pitch_ang_r  <= in_tdata[107:90];
            ax_r         <= 1'b0;
            state_r      <= ST_MARGIN_ISS;
          end
        end
        ST_MARGIN_ISS: state_r <= ST_MARGIN_WB;
        ST_MARGIN_WB: begin
          eff_r   <= eff_calc;
          state_r <= ST_SAT_CHK;
        end
        ST_SAT_CHK: begin
          if (sat_full) begin
            sat_r   <= gcra_pkg::ONE_Q12[12:0];
            state_r <= ST_FACT_ISS;
          end else begin
            state_r <= ST_DIV_RUN;
          end
        end
        ST_DIV_RUN: begin
          if (div_rsp.done) begin
            sat_r   <= div_rsp.quot;
            state_r <= ST_FACT_ISS;
          end
        end
        ST_FACT_ISS: state_r <= ST_FACT_WB;
        ST_FACT_WB: begin
          factor_r <= push_out ? 13'd0 : acc_rnd[12:0];
          state_r  <= ST_GIMB_ISS;
        end
        ST_GIMB_ISS: state_r <= ST_GIMB_WB;
        ST_GIMB_WB: begin
          gim_r   <= gim_clamp;
          state_r <= ST_SM1_ISS;
        end
        ST_SM1_ISS: state_r <= ST_SM2_ISS;
        ST_SM2_ISS: state_r <= ST_SM_WB;
        ST_SM_WB: begin
          // Filter output becomes the history for the next request.
          if (ax_r) begin
            prev_pitch_r <= cmd_now;
            state_r      <= ST_SHARE_ISS;
          end else begin
            prev_yaw_r <= cmd_now;
            ysat_r     <= sat_r;
            ax_r       <= 1'b1;
            state_r    <= ST_MARGIN_ISS;
          end
        end
        ST_SHARE_ISS: state_r <= ST_SHARE_WB;
        ST_SHARE_WB: begin
          share_r <= cfg.ratio + acc_rnd[12:0];
          state_r <= ST_CY_ISS;
        end
        ST_CY_ISS: state_r <= ST_DONE;
        ST_DONE: begin
          // Chassis yaw product is in the MAC now; publish when the slot frees.
          if (out_free) begin
            cy_r        <= cy_clamp;
            out_valid_r <= 1'b1;
            out_tdata_r <= {6'b0, cy_clamp, lat, fwd, prev_pitch_r, prev_yaw_r};
            out_tuser_r <= {(prev_pitch_r >= -gcra_pkg::HOLD_LSB) &&
                            (prev_pitch_r <= gcra_pkg::HOLD_LSB),
                            (prev_yaw_r >= -gcra_pkg::HOLD_LSB) &&
                            (prev_yaw_r <= gcra_pkg::HOLD_LSB)};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_tdata_r[95:90], cy_r, out_tdata_r[71:0]};
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

>>> hw/rtl/gcra_checker.sv
// ----------------------------------------------------------------------------
// Rate allocator port checker
// Watches the stream ports of the core and flags sequencing and flag errors.
// ----------------------------------------------------------------------------
`default_nettype none

module gcra_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [111:0] in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [95:0]  out_tdata,
  input wire logic [1:0]   out_tuser,
  input wire logic         cfg_psel,
  input wire logic         cfg_penable,
  input wire logic         cfg_pwrite,
  input wire logic [4:0]   cfg_paddr,
  input wire logic [31:0]  cfg_pwdata,
  input wire logic [31:0]  cfg_prdata,
  input wire logic         cfg_pready
);

  logic signed [17:0] yaw_cmd;
  logic signed [17:0] pitch_cmd;

  assign yaw_cmd   = out_tdata[17:0];
  assign pitch_cmd = out_tdata[35:18];

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The core works on one request at a time.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("core ready again in the cycle after a request");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser)))
    else $error("stalled result changed");

  // Hold flags agree with the filtered commands they describe.
  a_hold_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser[0] == ((yaw_cmd >= -18'sd4) && (yaw_cmd <= 18'sd4))) &&
                    (out_tuser[1] == ((pitch_cmd >= -18'sd4) && (pitch_cmd <= 18'sd4)))))
    else $error("hold flag does not match command");

endmodule

bind gimbal_chassis_rate_allocator_core gcra_checker u_gcra_checker (.*);

`default_nettype wire
